>>> hw/rtl/hiwf_pkg.sv
// ----------------------------------------------------------------------------
// hiwf_pkg: shared types and constants
// Field widths, register indexes and the block record handed between the
// row lifting stage and the column lifting stage.
// ----------------------------------------------------------------------------
`default_nettype none

package hiwf_pkg;

  localparam int PIXEL_W    = 8;
  localparam int LOW_W      = 8;   // row/column low coefficient
  localparam int HIGH_W     = 9;   // single high coefficient
  localparam int HH_W       = 10;  // high of high
  localparam int POS_W      = 9;   // block row / column
  localparam int CFG_W      = 10;
  localparam int ENTRY_W    = LOW_W + HIGH_W;  // line store word: {high, low}
  localparam int OUT_DATA_W = 56;  // 54 payload bits padded to whole bytes
  localparam int HALF_RESET = 256;

  typedef enum logic [0:0] {
    REG_HALF_WIDTH  = 1'b0,
    REG_HALF_HEIGHT = 1'b1
  } cfg_reg_t;

  // One completed pixel pair of an odd row, on its way to the column step
  typedef struct packed {
    logic                     frame_end;
    logic [POS_W-1:0]         block_col;
    logic [POS_W-1:0]         block_row;
    logic signed [HIGH_W-1:0] row_high;
    logic [LOW_W-1:0]         row_low;
  } blk_t;

endpackage

`default_nettype wire

>>> hw/rtl/hiwf_ram.sv
// ----------------------------------------------------------------------------
// hiwf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered and held when not read.
// ----------------------------------------------------------------------------
`default_nettype none

module hiwf_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 512,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [ADDR_W-1:0]        raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hiwf_row_lift.sv
// ----------------------------------------------------------------------------
// hiwf_row_lift: raster counters and row lifting step
// Tracks pixel column and row, holds the first pixel of each pair and forms
// the row low/high pair; steers it to the line store or the column stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hiwf_row_lift #(
  parameter int MAX_HALF_WIDTH  = 512,
  parameter int MAX_HALF_HEIGHT = 512,
  localparam int HW_W   = $clog2(MAX_HALF_WIDTH + 1),
  localparam int HH_W   = $clog2(MAX_HALF_HEIGHT + 1),
  localparam int ADDR_W = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [hiwf_pkg::PIXEL_W-1:0]  pixel,
  input  wire logic [HW_W-1:0]               half_width,
  input  wire logic [HH_W-1:0]               half_height,
  output logic                               store_we,
  output logic                               store_re,
  output logic      [ADDR_W-1:0]             store_addr,
  output logic      [hiwf_pkg::ENTRY_W-1:0]  store_wdata,
  output hiwf_pkg::blk_t                     blk
);

  localparam int COL_W  = $clog2(2 * MAX_HALF_WIDTH);
  localparam int ROW_W  = $clog2(2 * MAX_HALF_HEIGHT);

  logic [COL_W-1:0]              col, col_next;
  logic [ROW_W-1:0]              row, row_next;
  logic [hiwf_pkg::PIXEL_W-1:0]  held;
  logic                          col_last, row_last;
  logic signed [hiwf_pkg::HIGH_W-1:0] rh;
  logic [hiwf_pkg::HIGH_W:0]     rl_sum;

  assign col_last = (32'(col) + 32'd1) >= (32'(half_width) << 1);
  assign row_last = (32'(row) + 32'd1) >= (32'(half_height) << 1);

  always_comb begin
    col_next = COL_W'(32'(col) + 32'd1);
    row_next = row;
    if (col_last) begin
      col_next = '0;
      row_next = row_last ? '0 : ROW_W'(32'(row) + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      held <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
      if (!col[0]) begin
        held <= pixel;
      end
    end
  end

  // H = a - b, L = b + floor(H/2)
  assign rh     = $signed({1'b0, held}) - $signed({1'b0, pixel});
  assign rl_sum = {2'b00, pixel} +
                  {rh[hiwf_pkg::HIGH_W-1], rh[hiwf_pkg::HIGH_W-1], rh[hiwf_pkg::HIGH_W-1:1]};

  assign store_we    = accept && col[0] && !row[0];
  assign store_re    = accept && col[0] && row[0];
  assign store_addr  = ADDR_W'(col >> 1);
  assign store_wdata = {rh, rl_sum[hiwf_pkg::LOW_W-1:0]};

  assign blk.frame_end = col_last && row_last;
  assign blk.block_col = hiwf_pkg::POS_W'(col >> 1);
  assign blk.block_row = hiwf_pkg::POS_W'(row >> 1);
  assign blk.row_high  = rh;
  assign blk.row_low   = rl_sum[hiwf_pkg::LOW_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/hiwf_col_lift.sv
// ----------------------------------------------------------------------------
// hiwf_col_lift: column lifting step and output register
// Combines the stored top pair with the bottom pair and holds the result
// until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hiwf_col_lift (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             load,
  input  wire hiwf_pkg::blk_t                   blk_in,
  input  wire logic [hiwf_pkg::ENTRY_W-1:0]     top_entry,
  output logic                                  ready,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [hiwf_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                                  m_tlast
);

  hiwf_pkg::blk_t blk;
  logic           blk_valid;
  logic           out_free;

  logic [hiwf_pkg::LOW_W-1:0]         tl;
  logic signed [hiwf_pkg::HIGH_W-1:0] th;
  logic signed [hiwf_pkg::HIGH_W-1:0] ch_l;
  logic signed [hiwf_pkg::HH_W-1:0]   ch_h;
  logic [hiwf_pkg::HIGH_W:0]          cl_l;
  logic [hiwf_pkg::HH_W-1:0]          cl_h;

  assign out_free = !m_tvalid || m_tready;
  assign ready    = !blk_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (ready) begin
        blk_valid <= load;
      end
      if (out_free) begin
        m_tvalid <= blk_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      blk <= blk_in;
    end
  end

  // d = top - bottom, s = bottom + floor(d/2), on low and high rows
  assign tl   = top_entry[hiwf_pkg::LOW_W-1:0];
  assign th   = $signed(top_entry[hiwf_pkg::ENTRY_W-1:hiwf_pkg::LOW_W]);
  assign ch_l = $signed({1'b0, tl}) - $signed({1'b0, blk.row_low});
  assign cl_l = {2'b00, blk.row_low} + 10'(ch_l >>> 1);
  assign ch_h = hiwf_pkg::HH_W'(th) - hiwf_pkg::HH_W'(blk.row_high);
  assign cl_h = hiwf_pkg::HH_W'(blk.row_high) + (ch_h >>> 1);

  always_ff @(posedge clk) begin
    if (out_free && blk_valid) begin
      m_tdata <= {2'b00,
                  blk.block_col,
                  blk.block_row,
                  ch_h,
                  ch_l,
                  cl_h[hiwf_pkg::HIGH_W-1:0],
                  cl_l[hiwf_pkg::LOW_W-1:0]};
      m_tlast <= blk.frame_end;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/haar_integer_wavelet_forward_2d.sv
// ----------------------------------------------------------------------------
// haar_integer_wavelet_forward_2d: one-level 2-D integer Haar forward transform
// Raster pixel stream in, one 2x2 block of subband coefficients out per
// pixel pair of each odd row.
// ----------------------------------------------------------------------------
//
//  channel   | dir | width | carries
//  ----------+-----+-------+------------------------------------------------
//  s_axis    | in  | 8     | pixel, raster order
//  m_axis    | out | 56    | LL, HL, LH, HH, block row/col; tlast = frame end
//  cfg       | in  | 1+10  | register index, write data (ready out of reset)
//
//  One pixel per clock sustained while s_axis_tready is high. A result for
//  the pixel that completes its block passes the line store read, which lands
//  with the block record, then the column step into the output register.
//  The line store is written on even rows and read on odd rows only, so reads
//  and writes never meet on the same entry and need no forwarding.
//  Synchronous reset clears counters, held pixel and valid flags and sets both
//  half sizes to 256; the line store is not cleared. No transfer is taken
//  while reset is high.
//  A stalled output holds the column stage, and s_axis_tready drops only
//  while both the output and the column stage are full.
// ----------------------------------------------------------------------------
`default_nettype none

module haar_integer_wavelet_forward_2d #(
  parameter int MAX_HALF_WIDTH  = 512,
  parameter int MAX_HALF_HEIGHT = 512
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // pixel stream; tdata[7:0] pixel
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [hiwf_pkg::PIXEL_W-1:0]     s_axis_tdata,
  // block stream; tdata: [7:0] low_low, [16:8] rowhigh_collow,
  // [25:17] rowlow_colhigh, [35:26] high_high, [44:36] block_row,
  // [53:45] block_col, [55:54] zero; tlast = frame_end
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [hiwf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                                  m_axis_tlast,
  // register writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [0:0]                       cfg_index,
  input  wire logic [hiwf_pkg::CFG_W-1:0]       cfg_data
);

  localparam int HW_W   = $clog2(MAX_HALF_WIDTH + 1);
  localparam int HH_W   = $clog2(MAX_HALF_HEIGHT + 1);
  localparam int ADDR_W = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH) : 1;
  localparam int HW_RESET = (hiwf_pkg::HALF_RESET > MAX_HALF_WIDTH) ?
                            MAX_HALF_WIDTH : hiwf_pkg::HALF_RESET;
  localparam int HH_RESET = (hiwf_pkg::HALF_RESET > MAX_HALF_HEIGHT) ?
                            MAX_HALF_HEIGHT : hiwf_pkg::HALF_RESET;

  logic [HW_W-1:0] half_width, half_width_next;
  logic [HH_W-1:0] half_height, half_height_next;

  logic                         accept;
  logic                         store_we, store_re;
  logic [ADDR_W-1:0]            store_addr;
  logic [hiwf_pkg::ENTRY_W-1:0] store_wdata, store_rdata;
  hiwf_pkg::blk_t               blk;
  logic                         col_ready;

  // Register values are held already clamped: zero acts as one, anything
  // above the maximum acts as the maximum.
  assign cfg_ready = !rst;

  always_comb begin
    half_width_next  = half_width;
    half_height_next = half_height;
    if (32'(cfg_data) == 32'd0) begin
      half_width_next  = HW_W'(1);
      half_height_next = HH_W'(1);
    end else begin
      half_width_next  = (32'(cfg_data) > 32'(MAX_HALF_WIDTH)) ?
                         HW_W'(MAX_HALF_WIDTH) : HW_W'(cfg_data);
      half_height_next = (32'(cfg_data) > 32'(MAX_HALF_HEIGHT)) ?
                         HH_W'(MAX_HALF_HEIGHT) : HH_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width  <= HW_W'(HW_RESET);
      half_height <= HH_W'(HH_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hiwf_pkg::REG_HALF_WIDTH:  half_width  <= half_width_next;
        hiwf_pkg::REG_HALF_HEIGHT: half_height <= half_height_next;
        default: ;
      endcase
    end
  end

  // Pixel transfer; the column stage must have room for a possible block
  assign s_axis_tready = col_ready && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;

  hiwf_row_lift #(
    .MAX_HALF_WIDTH  (MAX_HALF_WIDTH),
    .MAX_HALF_HEIGHT (MAX_HALF_HEIGHT)
  ) u_row (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel       (s_axis_tdata),
    .half_width  (half_width),
    .half_height (half_height),
    .store_we    (store_we),
    .store_re    (store_re),
    .store_addr  (store_addr),
    .store_wdata (store_wdata),
    .blk         (blk)
  );

  // Line store: row low/high of every pair of the last even row
  hiwf_ram #(
    .WIDTH (hiwf_pkg::ENTRY_W),
    .DEPTH (MAX_HALF_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_addr),
    .wdata (store_wdata),
    .re    (store_re),
    .raddr (store_addr),
    .rdata (store_rdata)
  );

  // The read issued with a block lands together with that block's record
  hiwf_col_lift u_col (
    .clk       (clk),
    .rst       (rst),
    .load      (store_re),
    .blk_in    (blk),
    .top_entry (store_rdata),
    .ready     (col_ready),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata),
    .m_tlast   (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> tb/tb_haar_integer_wavelet_forward_2d.sv
// ----------------------------------------------------------------------------
// tb_haar_integer_wavelet_forward_2d: self-checking bench for the 2-D Haar block
// Streams raster pixels through the forward transform under a range of frame
// sizes. Each pixel transfer updates a behavioural copy of the row and column
// lifting steps, and each block transfer is compared field by field with the
// oldest predicted block. Both streams idle at random; one stretch holds the
// output off long enough to back the block up into its pixel input.
// ----------------------------------------------------------------------------

module tb_haar_integer_wavelet_forward_2d;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF_NS   = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int MAX_HALF      = 512;
  localparam int SETTLE_CYCLES = 4;     // settling time after the last predicted block
  localparam int END_CYCLES    = 8;
  localparam int HOLD_CYCLES   = 80;    // long output stall for the back-pressure run
  localparam int HOLD_PIXELS   = 24;    // pixels offered during the long stall
  localparam int RANDOM_ITEMS  = 16;    // random pixels per idling mode
  localparam int TIMEOUT_NS    = 400_000;

  // One predicted 2x2 block, as it travels on m_axis
  typedef struct packed {
    logic                               frame_end;
    logic [hiwf_pkg::POS_W-1:0]         block_col;
    logic [hiwf_pkg::POS_W-1:0]         block_row;
    logic signed [hiwf_pkg::HH_W-1:0]   high_high;
    logic signed [hiwf_pkg::HIGH_W-1:0] rowlow_colhigh;
    logic signed [hiwf_pkg::HIGH_W-1:0] rowhigh_collow;
    logic [hiwf_pkg::LOW_W-1:0]         low_low;
  } coef_block_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the counters, held pixel and line store,
  // predicts a block on every second pixel of an odd row.
  // --------------------------------------------------------------------------
  class haar_block_scoreboard;
    logic [hiwf_pkg::CFG_W-1:0]   half_width_reg;
    logic [hiwf_pkg::CFG_W-1:0]   half_height_reg;
    logic [hiwf_pkg::ENTRY_W-1:0] line_store [MAX_HALF];     // {row high, row low}
    bit                           store_written [MAX_HALF];
    logic [hiwf_pkg::PIXEL_W-1:0] held_pixel;
    int unsigned                  pixel_col;
    int unsigned                  pixel_row;
    coef_block_t                  expected_blocks [$];
    int                           errors;

    function new();
      half_width_reg  = hiwf_pkg::CFG_W'(hiwf_pkg::HALF_RESET);
      half_height_reg = hiwf_pkg::CFG_W'(hiwf_pkg::HALF_RESET);
      held_pixel      = '0;
      pixel_col       = 0;
      pixel_row       = 0;
      errors          = 0;
      foreach (store_written[i]) store_written[i] = 1'b0;
    endfunction

    // zero acts as one, anything above the maximum saturates
    function int unsigned clamp_half(logic [hiwf_pkg::CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_HALF) return MAX_HALF;
      return v;
    endfunction

    function void note_reg(hiwf_pkg::cfg_reg_t idx, logic [hiwf_pkg::CFG_W-1:0] v);
      case (idx)
        hiwf_pkg::REG_HALF_WIDTH:  half_width_reg  = v;
        hiwf_pkg::REG_HALF_HEIGHT: half_height_reg = v;
        default: ;
      endcase
    endfunction

    // A new width is only safe if the rest of an odd row reads line store
    // entries that some even row has already filled.
    function bit width_safe(logic [hiwf_pkg::CFG_W-1:0] v);
      int unsigned hw;
      int unsigned first;
      hw    = clamp_half(v);
      first = pixel_col >> 1;
      if (pixel_row[0] == 1'b0) return 1'b1;
      for (int unsigned p = first; p < MAX_HALF; p++)
        if ((p < hw || (p == first && pixel_col[0])) && !store_written[p]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_pixel(logic [hiwf_pkg::PIXEL_W-1:0] px);
      int unsigned hw;
      int unsigned hh;
      int unsigned pair;
      int          rh, rl, tl, th, dl, sl, dh, sh;
      coef_block_t b;
      hw   = clamp_half(half_width_reg);
      hh   = clamp_half(half_height_reg);
      pair = pixel_col >> 1;
      if (pixel_col[0] == 1'b0) begin
        held_pixel = px;
      end else begin
        // row lifting: high = a - b, low = b + floor(high / 2)
        rh = int'(held_pixel) - int'(px);
        rl = int'(px) + (rh >>> 1);
        if (pixel_row[0] == 1'b0) begin
          line_store[pair]    = {rh[hiwf_pkg::HIGH_W-1:0], rl[hiwf_pkg::LOW_W-1:0]};
          store_written[pair] = 1'b1;
        end else begin
          // column lifting on the low pair and on the high pair
          tl = int'(line_store[pair][hiwf_pkg::LOW_W-1:0]);
          th = int'($signed(line_store[pair][hiwf_pkg::ENTRY_W-1:hiwf_pkg::LOW_W]));
          dl = tl - rl;
          sl = rl + (dl >>> 1);
          dh = th - rh;
          sh = rh + (dh >>> 1);
          b.low_low        = sl[hiwf_pkg::LOW_W-1:0];
          b.rowhigh_collow = sh[hiwf_pkg::HIGH_W-1:0];
          b.rowlow_colhigh = dl[hiwf_pkg::HIGH_W-1:0];
          b.high_high      = dh[hiwf_pkg::HH_W-1:0];
          b.block_row      = hiwf_pkg::POS_W'(pixel_row >> 1);
          b.block_col      = hiwf_pkg::POS_W'(pair);
          b.frame_end      = (pixel_col + 1 >= 2 * hw) && (pixel_row + 1 >= 2 * hh);
          expected_blocks.insert(expected_blocks.size(), b);
        end
      end
      pixel_col++;
      if (pixel_col >= 2 * hw) begin
        pixel_col = 0;
        pixel_row++;
        if (pixel_row >= 2 * hh) pixel_row = 0;
      end
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_block(logic [hiwf_pkg::OUT_DATA_W-1:0] data, logic last);
      coef_block_t want;
      if (expected_blocks.size() == 0) begin
        $error("block transfer with nothing expected: tdata %h tlast %b", data, last);
        errors++;
        return;
      end
      want = expected_blocks.pop_front();
      check_field("low_low", int'(want.low_low), int'(data[7:0]));
      check_field("rowhigh_collow", int'(want.rowhigh_collow), int'($signed(data[16:8])));
      check_field("rowlow_colhigh", int'(want.rowlow_colhigh), int'($signed(data[25:17])));
      check_field("high_high", int'(want.high_high), int'($signed(data[35:26])));
      check_field("block_row", int'(want.block_row), int'(data[44:36]));
      check_field("block_col", int'(want.block_col), int'(data[53:45]));
      check_field("frame_end", int'(want.frame_end), int'(last));
      check_field("tdata padding", 0, int'(data[55:54]));
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [hiwf_pkg::PIXEL_W-1:0]    s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [hiwf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_valid     = 1'b0;
  logic                            cfg_ready;
  logic [0:0]                      cfg_index     = hiwf_pkg::REG_HALF_WIDTH;
  logic [hiwf_pkg::CFG_W-1:0]      cfg_data      = '0;

  // idling in percent of cycles; changed per stimulus stage
  int send_idle_pct = 11;
  int recv_idle_pct = 50;

  // long output stall: main process raises a request, receiver counts it out
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  haar_block_scoreboard sb = new();

  // corner blocks on a 2x2 frame: top pair then bottom pair, driving each
  // coefficient to an end of its range, high_high and rowhigh_collow to both
  logic [hiwf_pkg::PIXEL_W-1:0] corner_pixels [24] = '{
    8'd255, 8'd0,   8'd0,   8'd255,   // high_high at +510
    8'd0,   8'd255, 8'd255, 8'd0,     // high_high at -510
    8'd255, 8'd255, 8'd255, 8'd255,   // low_low at 255
    8'd255, 8'd255, 8'd0,   8'd0,     // rowlow_colhigh at +255
    8'd255, 8'd0,   8'd255, 8'd0,     // rowhigh_collow at +255
    8'd0,   8'd255, 8'd0,   8'd255    // rowhigh_collow at -255
  };

  always begin
    #(CLK_HALF_NS) clk = 1'b1;
    #(CLK_HALF_NS) clk = 1'b0;
  end

  haar_integer_wavelet_forward_2d #(
    .MAX_HALF_WIDTH (MAX_HALF),
    .MAX_HALF_HEIGHT(MAX_HALF)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Receiver: checks each block transfer at the edge it completes on, then
  // picks tready for the next cycle (random idling or a counted long stall).
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_block(m_axis_tdata, m_axis_tlast);
    if (hold_served != hold_requests) begin
      hold_served   <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic logic [hiwf_pkg::PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return hiwf_pkg::PIXEL_W'($urandom);
    endcase
  endfunction

  // Offers one pixel and returns on the edge it transfers; tvalid is left high
  // so back-to-back pixels need no second assignment in one step.
  task automatic send_pixel(input logic [hiwf_pkg::PIXEL_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_pixel(px);
  endtask

  task automatic send_run(input int count);
    repeat (count) send_pixel(rand_pixel());
    s_axis_tvalid <= 1'b0;
  endtask

  // cfg_valid stays high across consecutive writes, dropped by configure
  task automatic write_reg(input hiwf_pkg::cfg_reg_t idx,
                           input logic [hiwf_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_reg(idx, val);
  endtask

  task automatic configure(input bit do_w, input logic [hiwf_pkg::CFG_W-1:0] w,
                           input bit do_h, input logic [hiwf_pkg::CFG_W-1:0] h);
    if (do_w) write_reg(hiwf_pkg::REG_HALF_WIDTH, w);
    if (do_h) write_reg(hiwf_pkg::REG_HALF_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // wait for every predicted block, then let the pipeline empty
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Shrink to a 2x2 frame (always safe mid-frame), pad up to a frame start,
  // then set the wanted sizes.
  task automatic start_frame(input logic [hiwf_pkg::CFG_W-1:0] w,
                             input logic [hiwf_pkg::CFG_W-1:0] h);
    drain();
    configure(1'b1, hiwf_pkg::CFG_W'(1), 1'b1, hiwf_pkg::CFG_W'(1));
    while (sb.pixel_col != 0 || sb.pixel_row != 0) send_pixel(rand_pixel());
    s_axis_tvalid <= 1'b0;
    drain();
    configure(1'b1, w, 1'b1, h);
  endtask

  // Small random frames with size changes that land mid-frame; a width that
  // would make an odd row read a never-filled line store entry is skipped.
  task automatic random_stretch(input int items);
    int                         sent;
    int                         n;
    bit                         do_w;
    bit                         do_h;
    logic [hiwf_pkg::CFG_W-1:0] w;
    logic [hiwf_pkg::CFG_W-1:0] h;
    sent = 0;
    while (sent < items) begin
      drain();
      if ($urandom_range(2) == 0) begin
        w    = ($urandom_range(9) == 0) ? '0 : hiwf_pkg::CFG_W'($urandom_range(1, 12));
        h    = ($urandom_range(9) == 0) ? '0 : hiwf_pkg::CFG_W'($urandom_range(1, 4));
        do_w = ($urandom_range(1) == 1) && sb.width_safe(w);
        do_h = ($urandom_range(1) == 1);
        configure(do_w, w, do_h, h);
      end
      n = $urandom_range(4, 24);
      send_run(n);
      sent += n;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: one full even row, then the first two blocks of the odd row
    send_run(2 * hiwf_pkg::HALF_RESET + 4);

    // corner blocks on 2x2 frames; zero sizes act as one, every block ends a frame
    start_frame('0, '0);
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    s_axis_tvalid <= 1'b0;

    // sender idles lightly, receiver half the time
    random_stretch(RANDOM_ITEMS);

    // back-pressure: output held off while pixels keep coming
    start_frame(hiwf_pkg::CFG_W'(2), hiwf_pkg::CFG_W'(2));
    hold_requests++;
    send_run(HOLD_PIXELS);

    // sender idles half the time, receiver lightly
    send_idle_pct = 50;
    recv_idle_pct = 11;
    random_stretch(RANDOM_ITEMS);

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_stretch(RANDOM_ITEMS);

    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/hiwf_pkg.sv
hw/rtl/hiwf_ram.sv
hw/rtl/hiwf_row_lift.sv
hw/rtl/hiwf_col_lift.sv
hw/rtl/haar_integer_wavelet_forward_2d.sv
tb/tb_haar_integer_wavelet_forward_2d.sv
